### rtl/core/albd_pkg.sv
`default_nettype none

package albd_pkg;

  localparam int ADC_BITS = 12;
  localparam int WIN_W    = 2 * ADC_BITS;
  localparam int MS_W     = 16;
  localparam int TS_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [ADC_BITS-1:0] LVL_MAX = {ADC_BITS{1'b1}};
  // empty window: min all ones, max zero
  localparam logic [WIN_W-1:0] WIN_RESET = {{ADC_BITS{1'b0}}, LVL_MAX};
  localparam logic [MS_W-1:0] DEBOUNCE_RESET = MS_W'(50);
  localparam logic [MS_W-1:0] HOLD_RESET     = MS_W'(1000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd7;

  // event codes
  localparam logic [2:0] EV_RIGHT   = 3'd0;
  localparam logic [2:0] EV_LEFT    = 3'd1;
  localparam logic [2:0] EV_CONFIRM = 3'd2;
  localparam logic [2:0] EV_BACK    = 3'd3;
  localparam logic [2:0] EV_VOLDOWN = 3'd4;
  localparam logic [2:0] EV_VOLUP   = 3'd5;
  localparam logic [2:0] EV_POWER   = 3'd6;
  localparam logic [2:0] NO_BUTTON  = 3'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [ADC_BITS-1:0] row1_level;
    logic [ADC_BITS-1:0] row2_level;
    logic                power_pressed;
    logic [TS_W-1:0]     now_ms;
  } poll_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_of_poll;
  } result_t;

  // events of one poll, oldest first
  typedef struct packed {
    logic       two;
    logic [2:0] first;
    logic [2:0] second;
  } pair_t;

endpackage

`default_nettype wire

### rtl/core/albd_front.sv
`default_nettype none

module albd_front
  import albd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire poll_t                poll,
  input  wire logic                 q_full,
  output logic                      q_push,
  output pair_t                     q_data,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIN_W-1:0]     cfg_data
);

  logic [WIN_W-1:0] right_window, left_window, confirm_window, back_window;
  logic [WIN_W-1:0] volup_window, row_two_floor_voldown;
  logic [MS_W-1:0]  debounce_ms, power_hold_ms;

  logic [2:0]      held_button;
  logic [TS_W-1:0] press_time;
  logic            held_fired;
  logic [TS_W-1:0] power_time;
  logic            power_running;
  logic            power_done;

  logic            accept;
  logic [2:0]      cur;
  logic [TS_W-1:0] nav_elapsed, hold_base, pwr_elapsed;
  logic            nav_fire, pwr_fire;

  function automatic logic in_win(input logic [ADC_BITS-1:0] lvl,
                                  input logic [WIN_W-1:0] w);
    return (lvl >= w[ADC_BITS-1:0]) && (lvl <= w[WIN_W-1:ADC_BITS]);
  endfunction

  assign accept = push && !q_full;

  always_comb begin
    if (in_win(poll.row1_level, right_window)) begin
      cur = EV_RIGHT;
    end else if (in_win(poll.row1_level, left_window)) begin
      cur = EV_LEFT;
    end else if (in_win(poll.row1_level, confirm_window)) begin
      cur = EV_CONFIRM;
    end else if (in_win(poll.row1_level, back_window)) begin
      cur = EV_BACK;
    end else if (poll.row2_level < row_two_floor_voldown[ADC_BITS-1:0]) begin
      cur = NO_BUTTON;
    end else if (poll.row2_level <= row_two_floor_voldown[WIN_W-1:ADC_BITS]) begin
      cur = EV_VOLDOWN;
    end else if (in_win(poll.row2_level, volup_window)) begin
      cur = EV_VOLUP;
    end else begin
      cur = NO_BUTTON;
    end

    // a newly seen button only starts timing
    nav_elapsed = poll.now_ms - press_time;
    nav_fire = (cur != NO_BUTTON) && (cur == held_button) && !held_fired &&
               (nav_elapsed >= TS_W'(debounce_ms));

    hold_base   = power_running ? power_time : poll.now_ms;
    pwr_elapsed = poll.now_ms - hold_base;
    pwr_fire    = poll.power_pressed && !power_done &&
                  (pwr_elapsed >= TS_W'(power_hold_ms));

    if (nav_fire) begin
      q_data.first  = cur;
      q_data.second = EV_POWER;
      q_data.two    = pwr_fire;
    end else begin
      q_data.first  = EV_POWER;
      q_data.second = EV_POWER;
      q_data.two    = 1'b0;
    end
    q_push = accept && (nav_fire || pwr_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_window          <= WIN_RESET;
      left_window           <= WIN_RESET;
      confirm_window        <= WIN_RESET;
      back_window           <= WIN_RESET;
      volup_window          <= WIN_RESET;
      row_two_floor_voldown <= WIN_RESET;
      debounce_ms           <= DEBOUNCE_RESET;
      power_hold_ms         <= HOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RIGHT:    right_window          <= cfg_data;
        REG_LEFT:     left_window           <= cfg_data;
        REG_CONFIRM:  confirm_window        <= cfg_data;
        REG_BACK:     back_window           <= cfg_data;
        REG_VOLUP:    volup_window          <= cfg_data;
        REG_ROW2:     row_two_floor_voldown <= cfg_data;
        REG_DEBOUNCE: debounce_ms           <= cfg_data[MS_W-1:0];
        REG_HOLD:     power_hold_ms         <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_button   <= NO_BUTTON;
      press_time    <= '0;
      held_fired    <= 1'b0;
      power_time    <= '0;
      power_running <= 1'b0;
      power_done    <= 1'b0;
    end else if (accept) begin
      if (cur == NO_BUTTON) begin
        held_button <= NO_BUTTON;
        held_fired  <= 1'b0;
      end else if (cur != held_button) begin
        held_button <= cur;
        press_time  <= poll.now_ms;
        held_fired  <= 1'b0;
      end else if (nav_fire) begin
        held_fired <= 1'b1;
      end

      if (poll.power_pressed) begin
        power_running <= 1'b1;
        power_time    <= hold_base;
        if (pwr_fire) begin
          power_done <= 1'b1;
        end
      end else begin
        power_running <= 1'b0;
        power_done    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/albd_queue.sv
`default_nettype none

module albd_queue
  import albd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire pair_t wr_data,
  output logic       full,
  input  wire logic  rd_en,
  output pair_t      rd_data,
  output logic       empty
);

  pair_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full))
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && empty))
    else $error("read from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on write");

endmodule

`default_nettype wire

### rtl/core/albd_back.sv
`default_nettype none

module albd_back
  import albd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire pair_t q_data,
  input  wire logic  q_empty,
  output logic       q_pop,
  output result_t    result,
  output logic       empty,
  input  wire logic  pop
);

  pair_t cur;
  logic  cur_valid;
  logic  idx;   // 0: first word of the poll, 1: second
  logic  last;
  logic  take;

  assign last  = !cur.two || idx;
  assign take  = pop && cur_valid;
  assign q_pop = !q_empty && (!cur_valid || (take && last));
  assign empty = !cur_valid;

  assign result.event_code   = idx ? cur.second : cur.first;
  assign result.last_of_poll = last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 1'b0;
    end else if (take) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/adc_ladder_button_debouncer.sv
`default_nettype none

// Ladder button decoder with debounce and power-hold detect. Each pushed word
// is one poll (two ladder ADC levels, power pin, millisecond timestamp); each
// popped word is one button event, at most two per poll (nav/volume first, then
// power), with last_of_poll set on the final one. A poll is taken every cycle
// while full is low: window matching, the timestamp subtract and the state
// update all finish in the accept cycle. Events drain at one per cycle through
// a four-entry queue of per-poll event pairs, so full rises only when the
// consumer stalls or two-event polls arrive faster than they drain. Config
// writes are always ready and take effect on the next cycle.
module adc_ladder_button_debouncer
  import albd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire poll_t                poll,
  output logic                      empty,
  input  wire logic                 pop,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIN_W-1:0]     cfg_data
);

  logic  q_push, q_full, q_pop, q_empty;
  pair_t q_wdata, q_rdata;

  assign full      = q_full;
  assign cfg_ready = 1'b1;

  albd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .poll      (poll),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  albd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  albd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

### tb/albd_tb_pkg.sv
package albd_tb_pkg;
  import albd_pkg::*;

  // Predicts the button and power events of each poll and holds them until
  // the block pops them.
  class button_event_board;
    logic [WIN_W-1:0] win [6];
    logic [MS_W-1:0]  debounce_ms;
    logic [MS_W-1:0]  hold_ms;
    logic [2:0]       held_button;
    logic [TS_W-1:0]  press_time;
    logic [TS_W-1:0]  power_time;
    bit               held_fired;
    bit               power_running;
    bit               power_done;
    result_t          events_due [$];
    int               errors;
    int               polls;
    int               events_seen;

    function new();
      foreach (win[i]) win[i] = WIN_RESET;
      debounce_ms   = DEBOUNCE_RESET;
      hold_ms       = HOLD_RESET;
      held_button   = NO_BUTTON;
      press_time    = '0;
      power_time    = '0;
      held_fired    = 1'b0;
      power_running = 1'b0;
      power_done    = 1'b0;
    endfunction

    task flag_mismatch(string what);
      $display("tb_top: mismatch: %s", what);
      errors++;
    endtask

    function bit in_win(logic [ADC_BITS-1:0] lvl, logic [WIN_W-1:0] w);
      return lvl >= w[ADC_BITS-1:0] && lvl <= w[WIN_W-1:ADC_BITS];
    endfunction

    function logic [2:0] nav_code(logic [ADC_BITS-1:0] lvl);
      if (in_win(lvl, win[REG_RIGHT])) return EV_RIGHT;
      if (in_win(lvl, win[REG_LEFT])) return EV_LEFT;
      if (in_win(lvl, win[REG_CONFIRM])) return EV_CONFIRM;
      if (in_win(lvl, win[REG_BACK])) return EV_BACK;
      return NO_BUTTON;
    endfunction

    // floor in the low half, volume down max in the high half
    function logic [2:0] vol_code(logic [ADC_BITS-1:0] lvl);
      if (lvl < win[REG_ROW2][ADC_BITS-1:0]) return NO_BUTTON;
      if (lvl <= win[REG_ROW2][WIN_W-1:ADC_BITS]) return EV_VOLDOWN;
      if (in_win(lvl, win[REG_VOLUP])) return EV_VOLUP;
      return NO_BUTTON;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
      case (idx)
        REG_DEBOUNCE: debounce_ms = data[MS_W-1:0];
        REG_HOLD:     hold_ms = data[MS_W-1:0];
        default:      win[idx] = data;
      endcase
    endfunction

    function void note_poll(poll_t p);
      logic [2:0]      cur;
      logic [2:0]      fired [$];
      logic [TS_W-1:0] elapsed;
      result_t         r;
      polls++;
      cur = nav_code(p.row1_level);
      if (cur == NO_BUTTON) cur = vol_code(p.row2_level);
      if (cur == NO_BUTTON) begin
        held_button = NO_BUTTON;
        held_fired  = 1'b0;
      end else if (cur != held_button) begin
        // a new button only starts timing
        held_button = cur;
        press_time  = p.now_ms;
        held_fired  = 1'b0;
      end else begin
        elapsed = p.now_ms - press_time;
        if (!held_fired && elapsed >= TS_W'(debounce_ms)) begin
          held_fired = 1'b1;
          fired.push_back(cur);
        end
      end
      if (p.power_pressed) begin
        if (!power_running) begin
          power_running = 1'b1;
          power_time    = p.now_ms;
        end
        elapsed = p.now_ms - power_time;
        if (!power_done && elapsed >= TS_W'(hold_ms)) begin
          power_done = 1'b1;
          fired.push_back(EV_POWER);
        end
      end else begin
        power_running = 1'b0;
        power_done    = 1'b0;
      end
      foreach (fired[k]) begin
        r.event_code   = fired[k];
        r.last_of_poll = (k == fired.size() - 1);
        events_due.push_back(r);
      end
    endfunction

    task check_event(result_t got);
      result_t want;
      events_seen++;
      if (events_due.size() == 0) begin
        flag_mismatch($sformatf("word %0d: event %0d with nothing pending",
                                events_seen, got.event_code));
        return;
      end
      want = events_due.pop_front();
      if (got.event_code !== want.event_code)
        flag_mismatch($sformatf("word %0d: event_code %0d, expected %0d",
                                events_seen, got.event_code, want.event_code));
      if (got.last_of_poll !== want.last_of_poll)
        flag_mismatch($sformatf("word %0d: last_of_poll %0b, expected %0b",
                                events_seen, got.last_of_poll, want.last_of_poll));
    endtask

    function int pending();
      return events_due.size();
    endfunction
  endclass

endpackage

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import albd_pkg::*;
  import albd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;

  // disjoint keypad windows, {max, min}
  localparam logic [WIN_W-1:0] KP_RIGHT   = {12'd300, 12'd0};
  localparam logic [WIN_W-1:0] KP_LEFT    = {12'd900, 12'd400};
  localparam logic [WIN_W-1:0] KP_CONFIRM = {12'd1600, 12'd1000};
  localparam logic [WIN_W-1:0] KP_BACK    = {12'd2300, 12'd1700};
  localparam logic [WIN_W-1:0] KP_VOLUP   = {12'd2600, 12'd1600};
  localparam logic [WIN_W-1:0] KP_ROW2    = {12'd1500, 12'd100};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  poll_t                poll = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RIGHT;
  logic [WIN_W-1:0]     cfg_data = '0;

  button_event_board sb = new();

  int              cycle_count = 0;
  int              gap_odds = 8;
  bit              calm = 1'b0;
  int              pop_hold = 0;
  int              writes = 0;
  int              settings = 1;
  logic [TS_W-1:0] clock_ms = '0;
  logic [2:0]      g_cur = NO_BUTTON;
  int              g_left = 0;
  logic            pw_on = 1'b0;
  int              pw_left = 0;

  adc_ladder_button_debouncer i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .poll      (poll),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: timed out after %0d cycles, %0d events still pending",
             cycle_count, sb.pending());
    $display("tb_top: done, errors");
    $finish;
  end

  // consumer side: random stall bursts except in the calm stretch
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if ($urandom_range(0, gap_odds) == 0) begin
      pop_hold = $urandom_range(0, 11);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_event(result);
  end

  task send_poll(poll_t p);
    @(negedge clk);
    if (!calm && $urandom_range(0, gap_odds) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push <= 1'b1;
    poll <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_poll(p);
  endtask

  task send(int l1, int l2, logic pw, logic [TS_W-1:0] t);
    poll_t p;
    p.row1_level    = l1[ADC_BITS-1:0];
    p.row2_level    = l2[ADC_BITS-1:0];
    p.power_pressed = pw;
    p.now_ms        = t;
    send_poll(p);
  endtask

  // stop pushing, let every pending event drain, then let the block idle
  // before the registers change
  task drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_windows(logic [WIN_W-1:0] right, logic [WIN_W-1:0] left,
                   logic [WIN_W-1:0] confirm, logic [WIN_W-1:0] back,
                   logic [WIN_W-1:0] volup, logic [WIN_W-1:0] row2);
    write_reg(REG_RIGHT, right);
    write_reg(REG_LEFT, left);
    write_reg(REG_CONFIRM, confirm);
    write_reg(REG_BACK, back);
    write_reg(REG_VOLUP, volup);
    write_reg(REG_ROW2, row2);
    settings++;
  endtask

  // upper data bits are junk for the 16-bit registers
  task set_times(logic [MS_W-1:0] deb, logic [MS_W-1:0] hold);
    write_reg(REG_DEBOUNCE, {8'($urandom), deb});
    write_reg(REG_HOLD, {8'($urandom), hold});
  endtask

  task keypad();
    set_windows(KP_RIGHT, KP_LEFT, KP_CONFIRM, KP_BACK, KP_VOLUP, KP_ROW2);
  endtask

  // mostly ordered, sometimes inverted (matches nothing)
  function logic [WIN_W-1:0] rand_window();
    logic [ADC_BITS-1:0] a;
    logic [ADC_BITS-1:0] b;
    logic [ADC_BITS-1:0] lo;
    logic [ADC_BITS-1:0] hi;
    a  = ADC_BITS'($urandom);
    b  = ADC_BITS'($urandom);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if ($urandom_range(0, 4) == 0) return {lo, hi};
    return {hi, lo};
  endfunction

  function logic [ADC_BITS-1:0] level_in(logic [WIN_W-1:0] w);
    if (w[ADC_BITS-1:0] > w[WIN_W-1:ADC_BITS]) return ADC_BITS'($urandom);
    return ADC_BITS'($urandom_range(w[WIN_W-1:ADC_BITS], w[ADC_BITS-1:0]));
  endfunction

  // a level that decodes to no button on the given row, if one turns up
  function logic [ADC_BITS-1:0] free_level(bit row2);
    logic [ADC_BITS-1:0] l;
    for (int i = 0; i < 16; i++) begin
      l = ADC_BITS'($urandom);
      if (row2 && sb.vol_code(l) == NO_BUTTON) return l;
      if (!row2 && sb.nav_code(l) == NO_BUTTON) return l;
    end
    return l;
  endfunction

  function poll_t make_poll(logic [2:0] g, logic pw, logic [TS_W-1:0] t);
    poll_t p;
    p.power_pressed = pw;
    p.now_ms        = t;
    p.row1_level    = free_level(1'b0);
    p.row2_level    = free_level(1'b1);
    case (g) inside
      // nav codes line up with their register indexes
      EV_RIGHT, EV_LEFT, EV_CONFIRM, EV_BACK: p.row1_level = level_in(sb.win[g]);
      EV_VOLDOWN: p.row2_level = level_in(sb.win[REG_ROW2]);
      EV_VOLUP:   p.row2_level = level_in(sb.win[REG_VOLUP]);
      default: ;
    endcase
    return p;
  endfunction

  // held buttons and power presses of random length, small time steps,
  // occasional jumps anywhere in the timestamp range and raw noise polls
  task run_random(int count, int step_max);
    int    pick;
    poll_t p;
    for (int n = 0; n < count; n++) begin
      if (g_left == 0) begin
        pick   = $urandom_range(0, 6);
        g_cur  = (pick > EV_VOLUP) ? NO_BUTTON : pick[2:0];
        g_left = $urandom_range(1, 16);
      end
      g_left--;
      if (pw_left == 0) begin
        pw_on   = ~pw_on;
        pw_left = $urandom_range(1, 40);
      end
      pw_left--;
      if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      p = make_poll(g_cur, pw_on, clock_ms);
      if ($urandom_range(0, 9) == 0) begin
        p.row1_level = ADC_BITS'($urandom);
        p.row2_level = ADC_BITS'($urandom);
        p.power_pressed = 1'($urandom);
      end
      send_poll(p);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset registers: empty windows decode nothing, power hold of 1000
    send(2048, 2048, 1'b1, 32'd0);
    send(0, 0, 1'b1, 32'd999);
    send(4095, 4095, 1'b1, 32'd1000);
    send(4095, 0, 1'b0, 32'd1001);
    drain();

    // zero debounce: each button still needs a second poll to fire
    keypad();
    set_times(16'd0, 16'd0);
    send(150, 4095, 1'b0, 32'd10);
    send(150, 4095, 1'b0, 32'd10);
    send(650, 4095, 1'b0, 32'd11);
    send(650, 4095, 1'b0, 32'd11);
    send(1300, 0, 1'b0, 32'd12);
    send(1300, 0, 1'b0, 32'd12);
    send(2000, 4095, 1'b0, 32'd13);
    send(2000, 4095, 1'b0, 32'd14);
    send(4095, 800, 1'b0, 32'd15);
    send(4095, 800, 1'b0, 32'd16);
    send(4095, 2000, 1'b0, 32'd17);
    send(4095, 2000, 1'b0, 32'd18);
    // row one beats row two
    send(0, 100, 1'b0, 32'd19);
    send(0, 100, 1'b0, 32'd20);
    // zero hold fires on the first pressed poll
    send(4095, 4095, 1'b1, 32'd30);
    send(4095, 4095, 1'b0, 32'd31);
    send(150, 4095, 1'b0, 32'd32);
    send(150, 4095, 1'b1, 32'd33);
    drain();

    // press just before the timestamp wraps
    gap_odds = 10;
    set_times(16'd20, 16'd60);
    send(150, 4095, 1'b0, 32'hFFFF_FFFF);
    send(150, 4095, 1'b0, 32'h0000_0012);
    send(150, 4095, 1'b0, 32'h0000_0013);
    clock_ms = 32'h0000_0013;
    run_random(250, 8);
    drain();

    gap_odds = 4;
    set_windows(rand_window(), rand_window(), rand_window(), rand_window(),
                rand_window(), rand_window());
    set_times(MS_W'($urandom_range(0, 30)), MS_W'($urandom_range(0, 100)));
    run_random(250, 10);
    drain();

    // full-range right window, longest times
    gap_odds = 20;
    set_windows({12'd4095, 12'd0}, rand_window(), rand_window(), rand_window(),
                rand_window(), rand_window());
    set_times(16'hFFFF, 16'hFFFF);
    run_random(200, 8);
    drain();

    gap_odds = 6;
    keypad();
    set_times(16'd0, 16'd0);
    run_random(250, 3);
    drain();

    // single-level windows, an inverted back window, row two floor at zero
    gap_odds = 12;
    set_windows({12'd0, 12'd0}, {12'd4095, 12'd4095}, {12'd2048, 12'd2048},
                {12'd100, 12'd900}, {12'd4095, 12'd1}, {12'd0, 12'd0});
    set_times(16'd5, 16'd10);
    run_random(250, 4);
    drain();

    calm = 1'b1;
    keypad();
    set_times(MS_W'($urandom_range(0, 20)), MS_W'($urandom_range(0, 80)));
    run_random(300, 6);
    drain();
    repeat (12) @(posedge clk);

    $display("tb_top: %0d polls across %0d register settings (%0d register writes)",
             sb.polls, settings, writes);
    $display("tb_top: %0d events compared, %0d mismatches", sb.events_seen, sb.errors);
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/core/albd_pkg.sv
rtl/core/albd_front.sv
rtl/core/albd_queue.sv
rtl/core/albd_back.sv
rtl/core/adc_ladder_button_debouncer.sv
tb/albd_tb_pkg.sv
tb/tb_top.sv
